>>> hdl/serial_command_clock_defines.svh
// assertion macros shared by the checker of the serial command clock
`ifndef SERIAL_COMMAND_CLOCK_DEFINES_SVH
`define SERIAL_COMMAND_CLOCK_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define SCC_ASSERT_IMPLY(lbl, lhs, rhs) \
   lbl: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("serial_command_clock assertion failed");

// next-cycle implication, quiet while reset is high
`define SCC_ASSERT_NEXT(lbl, lhs, rhs) \
   lbl: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("serial_command_clock assertion failed");

// next-cycle implication that also holds across reset
`define SCC_ASSERT_NEXT_ALWAYS(lbl, lhs, rhs) \
   lbl: assert property (@(posedge clock) (lhs) |=> (rhs)) \
      else $error("serial_command_clock assertion failed");

`endif

>>> hdl/scc_pkg.sv
// shared types, constants and helpers of the serial command clock
package scc_pkg;

   // default parameter values
   localparam int TICKS_PER_SECOND_DEFAULT = 100;
   localparam int MAX_FRAME_INDEX_DEFAULT  = 40;

   // frame storage geometry
   localparam int STORE_DEPTH = 9;
   localparam int STORE_IDX_W = 4;
   localparam int INDEX_W     = 6;

   // command queue geometry
   localparam int QUEUE_DEPTH = 2;

   // field widths
   localparam int TIME_W = 7;
   localparam int CHAR_W = 8;

   // clock limits
   localparam logic [TIME_W-1:0] SECONDS_PER_MINUTE = 7'd60;
   localparam logic [TIME_W-1:0] MINUTES_PER_HOUR   = 7'd60;
   localparam logic [TIME_W-1:0] HOURS_PER_DAY      = 7'd24;

   // characters of the serial protocol
   localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_HASH  = 8'h23;
   localparam logic [CHAR_W-1:0] CHAR_SET   = 8'h53;
   localparam logic [CHAR_W-1:0] CHAR_TEXT  = 8'h4D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   // input item kinds
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // commands handed from front to back
   typedef enum logic [2:0] {
      CMD_NONE     = 3'd0,
      CMD_TICK     = 3'd1,
      CMD_SET_TIME = 3'd2,
      CMD_SET_TEXT = 3'd3,
      CMD_REJECT   = 3'd4
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [TIME_W-1:0] hours;
      logic [TIME_W-1:0] minutes;
      logic [TIME_W-1:0] seconds;
      logic [CHAR_W-1:0] text_first;
      logic [CHAR_W-1:0] text_second;
      logic [CHAR_W-1:0] text_third;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic is_digit(input logic [CHAR_W-1:0] ch);
      return (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   endfunction

   // two ascii digits to a value; the low nibble of a digit is its value
   function automatic logic [TIME_W-1:0] pair_value(input logic [CHAR_W-1:0] tens,
                                                    input logic [CHAR_W-1:0] ones);
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] o;
      t = {3'b000, tens[3:0]};
      o = {3'b000, ones[3:0]};
      return (t << 3) + (t << 1) + o;
   endfunction

endpackage

>>> hdl/scc_front.sv
// front part: accepts items, assembles frames and classifies them into commands
module scc_front
   import scc_pkg::*;
#(
   parameter int MAX_FRAME_INDEX = MAX_FRAME_INDEX_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   input  logic [CHAR_W-1:0]   req_rx_byte,
   input  queue_status_type    q_status,
   output logic                push,
   output entry_type           push_entry
);

   localparam logic [INDEX_W-1:0] MaxIndex   = INDEX_W'(MAX_FRAME_INDEX);
   localparam logic [INDEX_W-1:0] StoreLimit = INDEX_W'(STORE_DEPTH);

   logic [CHAR_W-1:0]  frame_ff [STORE_DEPTH];
   logic [CHAR_W-1:0]  frame_in [STORE_DEPTH];
   logic [CHAR_W-1:0]  frame_eff [STORE_DEPTH];
   logic [INDEX_W-1:0] index_ff;
   logic [INDEX_W-1:0] index_in;
   logic               in_store;
   logic               digits_ok;

   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;
   assign in_store  = index_ff < StoreLimit;

   // frame as seen by a closing '#': zero at the current index
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         frame_eff[i] = (in_store && (index_ff[STORE_IDX_W-1:0] == STORE_IDX_W'(i)))
                      ? '0 : frame_ff[i];
      end
   end

   assign digits_ok = is_digit(frame_eff[1]) && is_digit(frame_eff[2]) &&
                      is_digit(frame_eff[4]) && is_digit(frame_eff[5]) &&
                      is_digit(frame_eff[7]) && is_digit(frame_eff[8]);

   // classify the offered item
   always_comb begin
      push_entry.cmd         = CMD_NONE;
      push_entry.hours       = pair_value(frame_eff[1], frame_eff[2]);
      push_entry.minutes     = pair_value(frame_eff[4], frame_eff[5]);
      push_entry.seconds     = pair_value(frame_eff[7], frame_eff[8]);
      push_entry.text_first  = frame_eff[1];
      push_entry.text_second = frame_eff[2];
      push_entry.text_third  = frame_eff[3];
      if (req_func == FUNC_TICK) begin
         push_entry.cmd = CMD_TICK;
      end else if (req_rx_byte == CHAR_HASH) begin
         if (frame_eff[0] == CHAR_SET) begin
            push_entry.cmd = digits_ok ? CMD_SET_TIME : CMD_REJECT;
         end else if (frame_eff[0] == CHAR_TEXT) begin
            push_entry.cmd = CMD_SET_TEXT;
         end
      end
   end

   // frame assembly on a byte transfer
   always_comb begin
      frame_in = frame_ff;
      index_in = index_ff;
      if (push && (req_func == FUNC_BYTE)) begin
         if (req_rx_byte == CHAR_STAR) begin
            index_in = '0;
         end else if (req_rx_byte == CHAR_HASH) begin
            if (in_store) begin
               frame_in[index_ff[STORE_IDX_W-1:0]] = '0;
            end
         end else if (index_ff < MaxIndex) begin
            if (in_store) begin
               frame_in[index_ff[STORE_IDX_W-1:0]] = req_rx_byte;
            end
            index_in = index_ff + INDEX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            frame_ff[i] <= '0;
         end
         index_ff <= '0;
      end else begin
         frame_ff <= frame_in;
         index_ff <= index_in;
      end
   end

endmodule

>>> hdl/scc_queue.sv
// short command queue between the front and back parts
module scc_queue
   import scc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        pop_entry,
   output queue_status_type q_status
);

   localparam int PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CountW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0]   LastPtr = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CountW-1:0] Full    = CountW'(QUEUE_DEPTH);

   entry_type          entries_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff;
   logic [PtrW-1:0]    wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff;
   logic [PtrW-1:0]    rd_ptr_in;
   logic [CountW-1:0]  count_ff;
   logic [CountW-1:0]  count_in;

   assign q_status.full  = count_ff == Full;
   assign q_status.empty = count_ff == '0;
   assign pop_entry      = entries_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hdl/scc_back.sv
// back part: runs commands against the clock and text and drives the result
module scc_back
   import scc_pkg::*;
#(
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  queue_status_type    q_status,
   input  entry_type           pop_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [TIME_W-1:0]   rsp_hours,
   output logic [TIME_W-1:0]   rsp_minutes,
   output logic [TIME_W-1:0]   rsp_seconds,
   output logic [CHAR_W-1:0]   rsp_text_first,
   output logic [CHAR_W-1:0]   rsp_text_second,
   output logic [CHAR_W-1:0]   rsp_text_third,
   output logic                rsp_second_elapsed,
   output logic                rsp_time_loaded,
   output logic                rsp_text_loaded,
   output logic                rsp_frame_rejected
);

   localparam int TickW = $clog2(TICKS_PER_SECOND + 1);
   localparam logic [TickW-1:0] LastTick = TickW'(TICKS_PER_SECOND - 1);

   logic [TickW-1:0]  tick_ff;
   logic [TickW-1:0]  tick_in;
   logic [TIME_W-1:0] hour_ff;
   logic [TIME_W-1:0] hour_in;
   logic [TIME_W-1:0] minute_ff;
   logic [TIME_W-1:0] minute_in;
   logic [TIME_W-1:0] second_ff;
   logic [TIME_W-1:0] second_in;
   logic [CHAR_W-1:0] text_ff [3];
   logic [CHAR_W-1:0] text_in [3];
   logic              valid_ff;
   logic              valid_in;
   logic              elapsed_ff;
   logic              elapsed_in;
   logic              tload_ff;
   logic              tload_in;
   logic              xload_ff;
   logic              xload_in;
   logic              reject_ff;
   logic              reject_in;
   logic [TIME_W-1:0] sec_inc;
   logic [TIME_W-1:0] min_inc;
   logic [TIME_W-1:0] hr_inc;
   logic              carry_min;
   logic              carry_hr;

   // take a command whenever the result slot is free or being emptied
   assign pop = !q_status.empty && (!valid_ff || rsp_ready);

   // one second of clock advance with carries
   always_comb begin
      sec_inc   = second_ff + TIME_W'(1);
      carry_min = sec_inc >= SECONDS_PER_MINUTE;
      min_inc   = minute_ff + TIME_W'(carry_min);
      carry_hr  = min_inc >= MINUTES_PER_HOUR;
      hr_inc    = hour_ff + TIME_W'(carry_hr);
   end

   // command execution
   always_comb begin
      tick_in    = tick_ff;
      hour_in    = hour_ff;
      minute_in  = minute_ff;
      second_in  = second_ff;
      text_in    = text_ff;
      elapsed_in = elapsed_ff;
      tload_in   = tload_ff;
      xload_in   = xload_ff;
      reject_in  = reject_ff;
      valid_in   = valid_ff && !rsp_ready;
      if (pop) begin
         valid_in   = 1'b1;
         elapsed_in = 1'b0;
         tload_in   = 1'b0;
         xload_in   = 1'b0;
         reject_in  = 1'b0;
         unique case (pop_entry.cmd)
            CMD_TICK: begin
               if (tick_ff == LastTick) begin
                  tick_in    = '0;
                  elapsed_in = 1'b1;
                  second_in  = carry_min ? '0 : sec_inc;
                  minute_in  = carry_hr ? '0 : min_inc;
                  hour_in    = (hr_inc >= HOURS_PER_DAY) ? '0 : hr_inc;
               end else begin
                  tick_in = tick_ff + TickW'(1);
               end
            end
            CMD_SET_TIME: begin
               hour_in   = pop_entry.hours;
               minute_in = pop_entry.minutes;
               second_in = pop_entry.seconds;
               tload_in  = 1'b1;
            end
            CMD_SET_TEXT: begin
               text_in[0] = pop_entry.text_first;
               text_in[1] = pop_entry.text_second;
               text_in[2] = pop_entry.text_third;
               xload_in   = 1'b1;
            end
            CMD_REJECT: begin
               reject_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         hour_ff    <= '0;
         minute_ff  <= '0;
         second_ff  <= '0;
         text_ff[0] <= CHAR_SPACE;
         text_ff[1] <= CHAR_SPACE;
         text_ff[2] <= CHAR_SPACE;
         valid_ff   <= 1'b0;
      end else begin
         tick_ff   <= tick_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         text_ff   <= text_in;
         valid_ff  <= valid_in;
      end
   end

   // result flags
   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      tload_ff   <= tload_in;
      xload_ff   <= xload_in;
      reject_ff  <= reject_in;
   end

   // state only moves on a pop, so it holds while a result waits
   assign rsp_valid          = valid_ff;
   assign rsp_hours          = hour_ff;
   assign rsp_minutes        = minute_ff;
   assign rsp_seconds        = second_ff;
   assign rsp_text_first     = text_ff[0];
   assign rsp_text_second    = text_ff[1];
   assign rsp_text_third     = text_ff[2];
   assign rsp_second_elapsed = elapsed_ff;
   assign rsp_time_loaded    = tload_ff;
   assign rsp_text_loaded    = xload_ff;
   assign rsp_frame_rejected = reject_ff;

endmodule

>>> hdl/serial_command_clock.sv
// top level of the serial command clock
// Each transfer in is either a received serial byte or one timer tick, and each gives exactly
// one result transfer with the clock time, the three text characters and four event flags.
// The block takes one item per cycle: the front part assembles and checks frames as bytes are
// transferred, a two-entry command queue passes one command per cycle to the back part unless
// results stall, and the back part updates the clock and text and holds the result in its
// output register; req_ready drops only when the queue is full because results are not being
// taken. There is no clearing pass after reset.
module serial_command_clock
   import scc_pkg::*;
#(
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEFAULT,
   parameter int MAX_FRAME_INDEX  = MAX_FRAME_INDEX_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   input  logic [CHAR_W-1:0]   req_rx_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [TIME_W-1:0]   rsp_hours,
   output logic [TIME_W-1:0]   rsp_minutes,
   output logic [TIME_W-1:0]   rsp_seconds,
   output logic [CHAR_W-1:0]   rsp_text_first,
   output logic [CHAR_W-1:0]   rsp_text_second,
   output logic [CHAR_W-1:0]   rsp_text_third,
   output logic                rsp_second_elapsed,
   output logic                rsp_time_loaded,
   output logic                rsp_text_loaded,
   output logic                rsp_frame_rejected
);

   queue_status_type q_status;
   logic             push;
   entry_type        push_entry;
   logic             pop;
   entry_type        pop_entry;

   // frame assembly and classification
   scc_front #(
      .MAX_FRAME_INDEX (MAX_FRAME_INDEX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .push        (push),
      .push_entry  (push_entry)
   );

   // command queue
   scc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   // clock, text and result
   scc_back #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .pop_entry          (pop_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hours          (rsp_hours),
      .rsp_minutes        (rsp_minutes),
      .rsp_seconds        (rsp_seconds),
      .rsp_text_first     (rsp_text_first),
      .rsp_text_second    (rsp_text_second),
      .rsp_text_third     (rsp_text_third),
      .rsp_second_elapsed (rsp_second_elapsed),
      .rsp_time_loaded    (rsp_time_loaded),
      .rsp_text_loaded    (rsp_text_loaded),
      .rsp_frame_rejected (rsp_frame_rejected)
   );

endmodule

>>> hdl/scc_checker.sv
// port-level checks of the serial command clock and their binding
`include "serial_command_clock_defines.svh"

module scc_checker
   import scc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [TIME_W-1:0]   rsp_hours,
   input  logic [TIME_W-1:0]   rsp_minutes,
   input  logic [TIME_W-1:0]   rsp_seconds,
   input  logic [CHAR_W-1:0]   rsp_text_first,
   input  logic [CHAR_W-1:0]   rsp_text_second,
   input  logic [CHAR_W-1:0]   rsp_text_third,
   input  logic                rsp_second_elapsed,
   input  logic                rsp_time_loaded,
   input  logic                rsp_text_loaded,
   input  logic                rsp_frame_rejected
);

   localparam int ShownW = 3 * TIME_W + 3 * CHAR_W;

   logic [3:0]        flags;
   logic [ShownW-1:0] shown;
   logic              time_legal;

   assign flags = {rsp_second_elapsed, rsp_time_loaded, rsp_text_loaded, rsp_frame_rejected};
   assign shown = {rsp_hours, rsp_minutes, rsp_seconds,
                   rsp_text_first, rsp_text_second, rsp_text_third};
   assign time_legal = (rsp_hours < HOURS_PER_DAY) && (rsp_minutes < MINUTES_PER_HOUR) &&
                       (rsp_seconds < SECONDS_PER_MINUTE);

   // a stalled result holds its clock and text
   `SCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(shown))

   // one item causes at most one kind of event
   `SCC_ASSERT_IMPLY(a_flags_exclusive, rsp_valid, $onehot0(flags))

   // a completed second always leaves a wrapped, legal time
   `SCC_ASSERT_IMPLY(a_elapsed_in_range, rsp_valid && rsp_second_elapsed, time_legal)

   // no result is left over from before reset
   `SCC_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid)

endmodule

bind serial_command_clock scc_checker u_scc_checker (.*);

>>> verif/serial_command_clock_tb.sv
// self-checking testbench of the serial command clock: frames, ticks and clock carries
module testbench;
   import scc_pkg::*;

   localparam int TICKS       = TICKS_PER_SECOND_DEFAULT;
   localparam int FRAME_CAP   = MAX_FRAME_INDEX_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 200;

   typedef struct {
      logic [TIME_W-1:0] hours;
      logic [TIME_W-1:0] minutes;
      logic [TIME_W-1:0] seconds;
      logic [CHAR_W-1:0] text_first;
      logic [CHAR_W-1:0] text_second;
      logic [CHAR_W-1:0] text_third;
      logic              second_elapsed;
      logic              time_loaded;
      logic              text_loaded;
      logic              frame_rejected;
   } reading_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_func;
   logic [CHAR_W-1:0] req_rx_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [TIME_W-1:0] rsp_hours;
   logic [TIME_W-1:0] rsp_minutes;
   logic [TIME_W-1:0] rsp_seconds;
   logic [CHAR_W-1:0] rsp_text_first;
   logic [CHAR_W-1:0] rsp_text_second;
   logic [CHAR_W-1:0] rsp_text_third;
   logic              rsp_second_elapsed;
   logic              rsp_time_loaded;
   logic              rsp_text_loaded;
   logic              rsp_frame_rejected;

   serial_command_clock #(
      .TICKS_PER_SECOND(TICKS),
      .MAX_FRAME_INDEX(FRAME_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hours(rsp_hours),
      .rsp_minutes(rsp_minutes),
      .rsp_seconds(rsp_seconds),
      .rsp_text_first(rsp_text_first),
      .rsp_text_second(rsp_text_second),
      .rsp_text_third(rsp_text_third),
      .rsp_second_elapsed(rsp_second_elapsed),
      .rsp_time_loaded(rsp_time_loaded),
      .rsp_text_loaded(rsp_text_loaded),
      .rsp_frame_rejected(rsp_frame_rejected)
   );

   // predicted block state
   logic [CHAR_W-1:0] frame_buf [STORE_DEPTH];
   int unsigned       frame_pos;
   int unsigned       hour_now;
   int unsigned       minute_now;
   int unsigned       second_now;
   int unsigned       tick_phase;
   logic [CHAR_W-1:0] text_buf [3];

   // readings predicted but not yet transferred out
   reading_type pending_readings [$];

   // bytes of the frame being built by a test
   logic [CHAR_W-1:0] frame_bytes [$];

   int items_sent;
   int mismatch_count;
   int loads_seen;
   int texts_seen;
   int rejects_seen;
   int seconds_seen;
   int burst_left;
   int ready_mode;
   int ready_left;

   always #5 clock = ~clock;

   // cycle limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   function automatic bit is_numeral(logic [CHAR_W-1:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic int unsigned numeral_pair(logic [CHAR_W-1:0] tens,
                                                logic [CHAR_W-1:0] ones);
      return (int'(tens) - int'(CHAR_ZERO)) * 10 + (int'(ones) - int'(CHAR_ZERO));
   endfunction

   task automatic clear_prediction();
      foreach (frame_buf[i]) frame_buf[i] = 8'h00;
      foreach (text_buf[i]) text_buf[i] = CHAR_SPACE;
      frame_pos  = 0;
      hour_now   = 0;
      minute_now = 0;
      second_now = 0;
      tick_phase = 0;
   endtask

   // advance the predicted state by one item and return the reading it gives
   function automatic reading_type next_reading(logic func, logic [CHAR_W-1:0] ch);
      reading_type r;
      r.second_elapsed = 1'b0;
      r.time_loaded    = 1'b0;
      r.text_loaded    = 1'b0;
      r.frame_rejected = 1'b0;
      if (func == FUNC_BYTE) begin
         if (ch == CHAR_STAR) begin
            frame_pos = 0;
         end else if (ch == CHAR_HASH) begin
            if (frame_pos < STORE_DEPTH) frame_buf[frame_pos] = 8'h00;
            if (frame_buf[0] == CHAR_SET) begin
               if (is_numeral(frame_buf[1]) && is_numeral(frame_buf[2]) &&
                   is_numeral(frame_buf[4]) && is_numeral(frame_buf[5]) &&
                   is_numeral(frame_buf[7]) && is_numeral(frame_buf[8])) begin
                  hour_now      = numeral_pair(frame_buf[1], frame_buf[2]);
                  minute_now    = numeral_pair(frame_buf[4], frame_buf[5]);
                  second_now    = numeral_pair(frame_buf[7], frame_buf[8]);
                  r.time_loaded = 1'b1;
               end else begin
                  r.frame_rejected = 1'b1;
               end
            end else if (frame_buf[0] == CHAR_TEXT) begin
               text_buf[0]   = frame_buf[1];
               text_buf[1]   = frame_buf[2];
               text_buf[2]   = frame_buf[3];
               r.text_loaded = 1'b1;
            end
         end else if (frame_pos < FRAME_CAP) begin
            if (frame_pos < STORE_DEPTH) frame_buf[frame_pos] = ch;
            frame_pos++;
         end
      end else begin
         tick_phase++;
         if (tick_phase >= TICKS) begin
            tick_phase = 0;
            r.second_elapsed = 1'b1;
            second_now++;
            if (second_now >= 60) begin
               second_now = 0;
               minute_now++;
            end
            if (minute_now >= 60) begin
               minute_now = 0;
               hour_now++;
            end
            if (hour_now >= 24) hour_now = 0;
         end
      end
      r.hours       = hour_now[TIME_W-1:0];
      r.minutes     = minute_now[TIME_W-1:0];
      r.seconds     = second_now[TIME_W-1:0];
      r.text_first  = text_buf[0];
      r.text_second = text_buf[1];
      r.text_third  = text_buf[2];
      return r;
   endfunction

   // one input transfer, with random bursts and gaps on the sender side
   task automatic send_item(logic func, logic [CHAR_W-1:0] ch);
      reading_type r;
      int          gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_func    <= func;
      req_rx_byte <= ch;
      do @(posedge clock); while (!req_ready);
      r = next_reading(func, ch);
      pending_readings.push_back(r);
      items_sent++;
      if (r.time_loaded) loads_seen++;
      if (r.text_loaded) texts_seen++;
      if (r.frame_rejected) rejects_seen++;
      if (r.second_elapsed) seconds_seen++;
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_item(FUNC_BYTE, frame_bytes[i]);
   endtask

   task automatic send_ticks(int n);
      repeat (n) send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
   endtask

   // sender holds off until every predicted reading has been transferred
   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   function automatic logic [CHAR_W-1:0] numeral(int v);
      return CHAR_ZERO + CHAR_W'(v % 10);
   endfunction

   // any byte that does not steer the frame
   function automatic logic [CHAR_W-1:0] plain_byte();
      logic [CHAR_W-1:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_STAR || c == CHAR_HASH);
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] non_numeral();
      logic [CHAR_W-1:0] c;
      case ($urandom_range(0, 4))
         0: c = CHAR_ZERO - 8'd1;
         1: c = CHAR_NINE + 8'd1;
         2: c = 8'h00;
         3: c = 8'hFF;
         default: begin
            do c = plain_byte(); while (is_numeral(c));
         end
      endcase
      return c;
   endfunction

   task automatic build_set_frame(int h, int m, int s,
                                  logic [CHAR_W-1:0] sep_a, logic [CHAR_W-1:0] sep_b);
      frame_bytes = {};
      frame_bytes.push_back(CHAR_STAR);
      frame_bytes.push_back(CHAR_SET);
      frame_bytes.push_back(numeral(h / 10));
      frame_bytes.push_back(numeral(h));
      frame_bytes.push_back(sep_a);
      frame_bytes.push_back(numeral(m / 10));
      frame_bytes.push_back(numeral(m));
      frame_bytes.push_back(sep_b);
      frame_bytes.push_back(numeral(s / 10));
      frame_bytes.push_back(numeral(s));
      frame_bytes.push_back(CHAR_HASH);
   endtask

   task automatic build_text_frame(int length);
      frame_bytes = {};
      frame_bytes.push_back(CHAR_STAR);
      frame_bytes.push_back(CHAR_TEXT);
      repeat (length) frame_bytes.push_back(plain_byte());
      frame_bytes.push_back(CHAR_HASH);
   endtask

   // power-up readout and a hash with an empty frame
   task automatic test_reset_state();
      send_item(FUNC_TICK, 8'hFF);
      send_item(FUNC_BYTE, CHAR_HASH);
   endtask

   // a good set frame with extreme separators, then one missing its digits
   task automatic test_set_frame();
      build_set_frame(12, 34, 56, 8'h00, 8'hFF);
      send_frame();
      frame_bytes = {CHAR_STAR, CHAR_SET, CHAR_HASH};
      send_frame();
   endtask

   task automatic test_text_frame();
      frame_bytes = {CHAR_STAR, CHAR_TEXT, 8'h61, 8'h7E, 8'h80, CHAR_HASH};
      send_frame();
   endtask

   // load times, mostly next to or past a carry, and run ticks up to the next second
   task automatic test_clock_carry();
      int cases [8][3] = '{'{23, 59, 59}, '{0, 0, 59}, '{0, 59, 59}, '{99, 99, 99},
                           '{24, 0, 0}, '{12, 34, 56}, '{23, 58, 59}, '{60, 60, 60}};
      foreach (cases[i]) begin
         build_set_frame(cases[i][0], cases[i][1], cases[i][2], plain_byte(), plain_byte());
         send_frame();
         send_ticks(TICKS - tick_phase);
      end
   endtask

   // mostly well-formed frames with random content, tick runs and noise
   task automatic test_random_traffic();
      int first;
      int pick;
      int spots [6] = '{2, 3, 5, 6, 8, 9};
      first = items_sent;
      pause_until_drained();
      while (items_sent - first < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            case ($urandom_range(0, 9))
               0, 1: build_set_frame(23, 59, $urandom_range(58, 59), plain_byte(), plain_byte());
               2: build_set_frame($urandom_range(0, 99), $urandom_range(0, 99),
                                  $urandom_range(0, 99), plain_byte(), plain_byte());
               default: build_set_frame($urandom_range(0, 23), $urandom_range(0, 59),
                                        $urandom_range(0, 59), plain_byte(), plain_byte());
            endcase
            send_frame();
         end else if (pick < 55) begin
            build_text_frame(($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 3);
            send_frame();
         end else if (pick < 65) begin
            build_set_frame($urandom_range(0, 99), $urandom_range(0, 99),
                            $urandom_range(0, 99), plain_byte(), plain_byte());
            if ($urandom_range(0, 1) == 0) begin
               frame_bytes[spots[$urandom_range(0, 5)]] = non_numeral();
            end else begin
               // short frame, stale positions take part
               frame_bytes = frame_bytes[0:$urandom_range(1, 8)];
               frame_bytes.push_back(CHAR_HASH);
            end
            send_frame();
         end else if (pick < 70) begin
            // frame running near or past the index cap
            frame_bytes = {CHAR_STAR};
            case ($urandom_range(0, 2))
               0: frame_bytes.push_back(CHAR_SET);
               1: frame_bytes.push_back(CHAR_TEXT);
               default: frame_bytes.push_back(plain_byte());
            endcase
            repeat ($urandom_range(FRAME_CAP - 2, FRAME_CAP + 6))
               frame_bytes.push_back(($urandom_range(0, 1) == 0) ? numeral($urandom_range(0, 9))
                                                                : plain_byte());
            frame_bytes.push_back(CHAR_HASH);
            send_frame();
         end else if (pick < 87) begin
            send_ticks($urandom_range(1, 120));
         end else if (pick < 97) begin
            repeat ($urandom_range(1, 8))
               send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end else begin
            pause_until_drained();
         end
      end
   endtask

   // receiver stall pattern: stretches of full rate, light and heavy stalls
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_left = $urandom_range(5, 60);
      end
      ready_left--;
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 1) != 0);
         default: rsp_ready <= ((ready_left % 8) < 2);
      endcase
   end

   // compare each result transfer with the oldest predicted reading
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: result transfer with no reading pending");
         end else begin
            want = pending_readings.pop_front();
            if (rsp_hours !== want.hours || rsp_minutes !== want.minutes ||
                rsp_seconds !== want.seconds || rsp_text_first !== want.text_first ||
                rsp_text_second !== want.text_second ||
                rsp_text_third !== want.text_third ||
                rsp_second_elapsed !== want.second_elapsed ||
                rsp_time_loaded !== want.time_loaded ||
                rsp_text_loaded !== want.text_loaded ||
                rsp_frame_rejected !== want.frame_rejected) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected %0d:%0d:%0d text %h %h %h flags %b%b%b%b",
                           want.hours, want.minutes, want.seconds, want.text_first,
                           want.text_second, want.text_third, want.second_elapsed,
                           want.time_loaded, want.text_loaded, want.frame_rejected);
                  $display("          actual   %0d:%0d:%0d text %h %h %h flags %b%b%b%b",
                           rsp_hours, rsp_minutes, rsp_seconds, rsp_text_first,
                           rsp_text_second, rsp_text_third, rsp_second_elapsed,
                           rsp_time_loaded, rsp_text_loaded, rsp_frame_rejected);
               end
            end
         end
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_BYTE;
      req_rx_byte    = 8'h00;
      rsp_ready      = 1'b0;
      items_sent     = 0;
      mismatch_count = 0;
      loads_seen     = 0;
      texts_seen     = 0;
      rejects_seen   = 0;
      seconds_seen   = 0;
      burst_left     = 0;
      ready_mode     = 0;
      ready_left     = 0;
      clear_prediction();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_set_frame();
      test_text_frame();
      test_clock_carry();
      test_random_traffic();

      // drain and let the pipeline settle
      pause_until_drained();
      repeat (20) @(posedge clock);

      $display("run: %0d items, %0d time loads, %0d text loads, %0d rejected frames",
               items_sent, loads_seen, texts_seen, rejects_seen);
      $display("run: %0d clock seconds advanced, %0d mismatches", seconds_seen,
               mismatch_count);
      if (mismatch_count == 0 && pending_readings.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/scc_pkg.sv
hdl/scc_front.sv
hdl/scc_queue.sv
hdl/scc_back.sv
hdl/serial_command_clock.sv
hdl/scc_checker.sv
verif/serial_command_clock_tb.sv
